@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int ROWS_DEF  = 25;
	localparam int COLS_DEF  = 80;
	localparam int Q_DEPTH   = 2;

	// cursor arithmetic widths, wide enough for the largest grid plus overflow
	localparam int ROW_W = 7;
	localparam int COL_W = 8;

	localparam logic [1:0]  REQ_PUT  = 2'd0;
	localparam logic [1:0]  REQ_READ = 2'd1;
	localparam logic [1:0]  REQ_MOVE = 2'd2;

	localparam logic [7:0]  CHAR_NL    = 8'd10;
	localparam logic [7:0]  CHAR_TAB   = 8'd9;
	localparam logic [7:0]  ATTR_RESET = 8'd13;
	localparam logic [15:0] BLANK_CELL = 16'h0F20;

	typedef enum logic [2:0] {
		CMD_NOP  = 3'd0,
		CMD_PUT  = 3'd1,
		CMD_NL   = 3'd2,
		CMD_TAB  = 3'd3,
		CMD_READ = 3'd4,
		CMD_MOVE = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [10:0]      idx;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} res_t;

endpackage

@@ rtl/tcw_fifo.sv @@
// ----------------------------------------------------------------------------
// tcw_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module tcw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tcw_pkg::Q_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, classifies them and saturates move targets.
// ----------------------------------------------------------------------------
module tcw_front #(
	parameter int GRID_ROWS = tcw_pkg::ROWS_DEF,
	parameter int GRID_COLS = tcw_pkg::COLS_DEF
) (
	input  logic          push,
	output logic          full,
	input  logic [1:0]    req_type,
	input  logic [7:0]    char_code,
	input  logic [4:0]    target_row,
	input  logic [6:0]    target_col,
	input  logic [10:0]   cell_index,
	input  logic          clearing,
	input  logic          cmd_full,
	output logic          cmd_push,
	output tcw_pkg::cmd_t cmd
);

	localparam int ROW_W = tcw_pkg::ROW_W;
	localparam int COL_W = tcw_pkg::COL_W;

	assign full     = cmd_full | clearing;
	assign cmd_push = push & ~full;

	always_comb begin
		cmd.ch  = char_code;
		cmd.idx = cell_index;

		if (target_row == '0)
			cmd.row = ROW_W'(1);
		else if (ROW_W'(target_row) > ROW_W'(GRID_ROWS))
			cmd.row = ROW_W'(GRID_ROWS);
		else
			cmd.row = ROW_W'(target_row);

		if (target_col == '0)
			cmd.col = COL_W'(1);
		else if (COL_W'(target_col) > COL_W'(GRID_COLS))
			cmd.col = COL_W'(GRID_COLS);
		else
			cmd.col = COL_W'(target_col);

		case (req_type)
			tcw_pkg::REQ_PUT: begin
				if (char_code == tcw_pkg::CHAR_NL)
					cmd.kind = tcw_pkg::CMD_NL;
				else if (char_code == tcw_pkg::CHAR_TAB)
					cmd.kind = tcw_pkg::CMD_TAB;
				else
					cmd.kind = tcw_pkg::CMD_PUT;
			end
			tcw_pkg::REQ_READ: cmd.kind = tcw_pkg::CMD_READ;
			tcw_pkg::REQ_MOVE: cmd.kind = tcw_pkg::CMD_MOVE;
			default:           cmd.kind = tcw_pkg::CMD_NOP;
		endcase
	end

endmodule

@@ rtl/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued requests: cursor update, cell write and read, scroll copy,
// last-row blanking and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int GRID_ROWS = tcw_pkg::ROWS_DEF,
	parameter int GRID_COLS = tcw_pkg::COLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  tcw_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output tcw_pkg::res_t res,
	output logic          clearing
);

	localparam int ROW_W      = tcw_pkg::ROW_W;
	localparam int COL_W      = tcw_pkg::COL_W;
	localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
	localparam int MOVE_CELLS = GRID_COLS * (GRID_ROWS - 1);
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CW         = $clog2(CELL_COUNT + 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_COPY  = 5'b01000,
		S_BLANK = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             pend_q, pend_d;
	logic [AW-1:0]    dst_q;
	logic             rd_oob_q;
	logic [15:0]      rd_data_q;
	logic [15:0]      screen_q [CELL_COUNT];
	logic [ROW_W-1:0] cur_row_q, nxt_row, res_row;
	logic [COL_W-1:0] cur_col_q, nxt_col, res_col, step_col;
	logic [ROW_W-1:0] step_row;
	logic [7:0]       attr_q;
	logic             scroll, cur_upd, rd_oob;
	logic             mem_we;
	logic [AW-1:0]    mem_wa, mem_ra, cur_ofs;
	logic [15:0]      mem_wd;
	logic [31:0]      res_ofs;

	assign clearing = (state_q == S_CLEAR);
	assign rd_oob   = (32'(cmd.idx) >= 32'(CELL_COUNT));

	// next cursor for the request at the head of the queue
	always_comb begin
		step_row = cur_row_q;
		step_col = cur_col_q;
		case (cmd.kind)
			tcw_pkg::CMD_PUT: step_col = cur_col_q + 1'b1;
			tcw_pkg::CMD_NL: begin
				step_row = cur_row_q + 1'b1;
				step_col = COL_W'(1);
			end
			tcw_pkg::CMD_TAB:  step_col = (cur_col_q + COL_W'(8)) & ~COL_W'(7);
			tcw_pkg::CMD_MOVE: begin
				step_row = cmd.row;
				step_col = cmd.col;
			end
			default: ;
		endcase
		nxt_row = step_row;
		nxt_col = step_col;
		if (step_col > COL_W'(GRID_COLS)) begin
			nxt_col = COL_W'(1);
			nxt_row = step_row + 1'b1;
		end
		scroll = (nxt_row > ROW_W'(GRID_ROWS));
		if (scroll)
			nxt_row = ROW_W'(GRID_ROWS);
	end

	assign cur_ofs = AW'(32'(cur_row_q - 1'b1) * 32'(GRID_COLS) + 32'(cur_col_q - 1'b1));
	assign res_row = (state_q == S_READ) ? cur_row_q : nxt_row;
	assign res_col = (state_q == S_READ) ? cur_col_q : nxt_col;
	assign res_ofs = 32'(res_row - 1'b1) * 32'(GRID_COLS) + 32'(res_col - 1'b1);

	always_comb begin
		res.cursor_row    = 5'(res_row);
		res.cursor_col    = 7'(res_col);
		res.cursor_offset = 11'(res_ofs);
		if (state_q == S_READ && !rd_oob_q) begin
			res.cell_char = rd_data_q[7:0];
			res.cell_attr = rd_data_q[15:8];
		end else begin
			res.cell_char = '0;
			res.cell_attr = '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pend_d   = 1'b0;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		cur_upd  = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		mem_ra   = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = AW'(cnt_q);
				if (cnt_q == CW'(CELL_COUNT - 1)) begin
					state_d = S_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					cur_upd = 1'b1;
					if (cmd.kind == tcw_pkg::CMD_READ) begin
						mem_ra  = rd_oob ? '0 : AW'(cmd.idx);
						state_d = S_READ;
					end else begin
						res_push = 1'b1;
						if (cmd.kind == tcw_pkg::CMD_PUT) begin
							mem_we = 1'b1;
							mem_wa = cur_ofs;
							mem_wd = {attr_q, cmd.ch};
						end
						if (scroll) begin
							state_d = S_COPY;
							cnt_d   = '0;
						end
					end
				end
			end
			S_READ: begin
				res_push = 1'b1;
				state_d  = S_IDLE;
			end
			S_COPY: begin
				if (pend_q) begin
					mem_we = 1'b1;
					mem_wa = dst_q;
					mem_wd = rd_data_q;
				end
				if (cnt_q != CW'(MOVE_CELLS)) begin
					mem_ra = AW'(cnt_q + CW'(GRID_COLS));
					pend_d = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end else begin
					state_d = S_BLANK;
					cnt_d   = '0;
				end
			end
			S_BLANK: begin
				mem_we = 1'b1;
				mem_wa = AW'(CW'(MOVE_CELLS) + cnt_q);
				mem_wd = tcw_pkg::BLANK_CELL;
				if (cnt_q == CW'(GRID_COLS - 1)) begin
					state_d = S_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// screen memory
	always_ff @(posedge clk) begin
		if (mem_we)
			screen_q[mem_wa] <= mem_wd;
		rd_data_q <= screen_q[mem_ra];
	end

	always_ff @(posedge clk) begin
		dst_q <= AW'(cnt_q);
		if (state_q == S_IDLE)
			rd_oob_q <= rd_oob;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			cur_row_q <= ROW_W'(1);
			cur_col_q <= COL_W'(1);
			attr_q    <= tcw_pkg::ATTR_RESET;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
			if (cur_upd) begin
				cur_row_q <= nxt_row;
				cur_col_q <= nxt_col;
			end
			if (cfg_we)
				attr_q <= cfg_wdata;
		end
	end

endmodule

@@ rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode character grid with cursor, put, move and cell read requests.
// ----------------------------------------------------------------------------
// Requests enter through push/full and are taken when push is high and full
// is low. Results leave through empty/pop: the oldest result sits on the
// result ports while empty is low and is taken when pop is high.
// cfg_we/cfg_wdata write the attribute stored with printed characters.
// A request queue of two entries parts the request side from the executing
// back end, and a result queue of two entries parts it from the receiver.
// Move, newline, tab and printed characters push their result as the back
// end takes them; a cell read pushes its result from the read state, after
// the registered read of the screen memory. A request that scrolls then
// copies the grid up one row, one cell copied per cycle, and blanks the
// last row, one cell blanked per cycle; the back end takes no request
// meanwhile. After reset the screen memory is cleared one cell per cycle;
// full stays high meanwhile. When the receiver stalls, the result queue
// fills, the back end stops and then full rises once the request queue is
// full.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int GRID_ROWS = tcw_pkg::ROWS_DEF,
	parameter int GRID_COLS = tcw_pkg::COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [4:0]  target_row,
	input  logic [6:0]  target_col,
	input  logic [10:0] cell_index,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [10:0] cursor_offset,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int CMD_W = $bits(tcw_pkg::cmd_t);
	localparam int RES_W = $bits(tcw_pkg::res_t);

	tcw_pkg::cmd_t cmd_in, cmd_out;
	tcw_pkg::res_t res_in, res_out;
	logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic          res_push, res_full;
	logic          clearing;

	tcw_front #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_front (
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.char_code (char_code),
		.target_row(target_row),
		.target_col(target_col),
		.cell_index(cell_index),
		.clearing  (clearing),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	tcw_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(tcw_pkg::Q_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	tcw_back #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in),
		.clearing (clearing)
	);

	tcw_fifo #(
		.WIDTH(RES_W),
		.DEPTH(tcw_pkg::Q_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign cursor_row    = res_out.cursor_row;
	assign cursor_col    = res_out.cursor_col;
	assign cursor_offset = res_out.cursor_offset;
	assign cell_char     = res_out.cell_char;
	assign cell_attr     = res_out.cell_attr;

`ifndef SYNTH
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !res_full && !cmd_empty)
		else $error("request taken without room for its result");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> !clearing)
		else $error("request accepted during the clearing pass");

	a_read_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd_out.kind == tcw_pkg::CMD_READ) |=> res_push)
		else $error("read result not delivered in the following cycle");
`endif

endmodule
